// File: design/fdct_pkg.sv
// Shared widths, cosine constants and the rotation schedule of the fixed-point 8x8 DCT.
package fdct_pkg;

    localparam int SAMPLE_W = 16;
    localparam int OPER_W   = 20;
    localparam int CONST_W  = 15;
    localparam int ACC_W    = 38;
    localparam int FRAC_W   = 15;
    localparam int STEP_W   = 4;
    localparam int LAST_STEP = 9;

    localparam logic [CONST_W-1:0] COS1 = 15'h7D8A;
    localparam logic [CONST_W-1:0] COS2 = 15'h7641;
    localparam logic [CONST_W-1:0] COS3 = 15'h6A6D;
    localparam logic [CONST_W-1:0] COS4 = 15'h5A82;
    localparam logic [CONST_W-1:0] COS5 = 15'h471C;
    localparam logic [CONST_W-1:0] COS6 = 15'h30FB;
    localparam logic [CONST_W-1:0] COS7 = 15'h18F8;
    localparam logic [ACC_W-1:0]   ROUND_HALF = 38'h4000;

    // Steps zero and one form the inner rotation, the others one frequency each.
    localparam logic [STEP_W-1:0] STEP_R5 = 4'd0;
    localparam logic [STEP_W-1:0] STEP_R6 = 4'd1;
    localparam logic [STEP_W-1:0] STEP_F0 = 4'd2;
    localparam logic [STEP_W-1:0] STEP_F1 = 4'd3;
    localparam logic [STEP_W-1:0] STEP_F2 = 4'd4;
    localparam logic [STEP_W-1:0] STEP_F3 = 4'd5;
    localparam logic [STEP_W-1:0] STEP_F4 = 4'd6;
    localparam logic [STEP_W-1:0] STEP_F7 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_F5 = 4'd8;
    localparam logic [STEP_W-1:0] STEP_F6 = 4'd9;

    function automatic logic [CONST_W-1:0] step_const(input logic [STEP_W-1:0] step,
                                                      input logic term);
        logic [CONST_W-1:0] c;
        begin
            case (step)
                STEP_F2: c = term ? COS2 : COS6;
                STEP_F3: c = term ? COS2 : COS6;
                STEP_F4: c = term ? COS1 : COS7;
                STEP_F7: c = term ? COS1 : COS7;
                STEP_F5: c = term ? COS5 : COS3;
                STEP_F6: c = term ? COS5 : COS3;
                default: c = COS4;
            endcase
            return c;
        end
    endfunction

    function automatic logic [2:0] step_freq(input logic [STEP_W-1:0] step);
        logic [2:0] f;
        begin
            case (step)
                STEP_F0: f = 3'd0;
                STEP_F1: f = 3'd4;
                STEP_F2: f = 3'd2;
                STEP_F3: f = 3'd6;
                STEP_F4: f = 3'd1;
                STEP_F7: f = 3'd7;
                STEP_F5: f = 3'd5;
                STEP_F6: f = 3'd3;
                default: f = 3'd0;
            endcase
            return f;
        end
    endfunction

    function automatic logic step_two_terms(input logic [STEP_W-1:0] step);
        return step >= STEP_F2;
    endfunction

endpackage

// File: design/fdct_mac.sv
// Bit-serial multiply-accumulate unit: one constant bit per cycle into a rounding accumulator.
module fdct_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  logic                                   clear,
    input  logic signed [fdct_pkg::OPER_W-1:0]     operand,
    input  logic        [fdct_pkg::CONST_W-1:0]    constant,
    output logic signed [fdct_pkg::ACC_W-1:0]      acc,
    output logic                                   idle
);

    logic signed [fdct_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [fdct_pkg::ACC_W-1:0] mcand_reg, mcand_next;
    logic [fdct_pkg::CONST_W-1:0] mplier_reg, mplier_next;
    logic [3:0] cnt_reg, cnt_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        if (load)
        begin
            acc_next    = clear ? fdct_pkg::ROUND_HALF : acc_reg;
            mcand_next  = {{(fdct_pkg::ACC_W-fdct_pkg::OPER_W){operand[fdct_pkg::OPER_W-1]}},
                           operand};
            mplier_next = constant;
            cnt_next    = 4'(fdct_pkg::CONST_W);
        end
        else if (cnt_reg != 4'd0)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign acc  = acc_reg;
    assign idle = (cnt_reg == 4'd0);

endmodule

// File: design/fixed_point_dct_8x8.sv
// Top level of the fixed-point 8x8 forward DCT: sample and transpose stores and the sequencer.
// Usage:
// The input channel takes one sample per transaction, accepted at a rising edge where
// start is high and busy is low. Samples arrive in row-major order of the 8x8 block.
// After the 64th sample busy rises and the block runs sixteen 8-point passes: eight
// over the rows into the transpose store, eight over the columns back into the sample
// store. Each pass loads eight values and then works through ten rotation steps on a
// bit-serial multiplier, sixteen products per pass. The 64 coefficients then leave in
// row-major order, one per cycle, each shown for one cycle with coef_valid high;
// last_of_block marks the 64th. busy falls while the last coefficient is shown, so
// the next block can start at once.
// The receiver cannot stall; results are never held back or repeated.
// Reset clears the sample count and the sequencer; the stores need no clearing since
// every entry is written before it is read.
module fixed_point_dct_8x8 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [fdct_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  coef_valid,
    output logic signed [fdct_pkg::SAMPLE_W-1:0]  coefficient,
    output logic        [5:0]                     coef_index,
    output logic                                  last_of_block
);

    typedef enum logic [2:0] {ST_COLLECT, ST_LOAD, ST_ISSUE, ST_WAIT, ST_EMIT} state_t;

    state_t state_reg, state_next;
    logic [5:0] count_reg, count_next;
    logic pass_reg, pass_next;
    logic [2:0] row_reg, row_next;
    logic [3:0] ld_reg, ld_next;
    logic [fdct_pkg::STEP_W-1:0] step_reg, step_next;
    logic term_reg, term_next;
    logic [5:0] emit_reg, emit_next;
    logic valid_reg, valid_next;
    logic [5:0] idx_reg, idx_next;
    logic signed [fdct_pkg::OPER_W-1:0] r5_reg, r5_next, r6_reg, r6_next;
    logic signed [fdct_pkg::SAMPLE_W-1:0] x_reg [8];

    logic signed [fdct_pkg::SAMPLE_W-1:0] s_mem [64];
    logic signed [fdct_pkg::SAMPLE_W-1:0] t_mem [64];
    logic signed [fdct_pkg::SAMPLE_W-1:0] s_rd_reg, t_rd_reg, ld_data, y;
    logic s_we, t_we;
    logic [5:0] s_waddr, s_raddr, t_raddr, y_addr;
    logic signed [fdct_pkg::SAMPLE_W-1:0] s_wdata;

    logic signed [fdct_pkg::OPER_W-1:0] xe [8];
    logic signed [fdct_pkg::OPER_W-1:0] e0, e1, e2, e3, e4, e5, e6, e7;
    logic signed [fdct_pkg::OPER_W-1:0] t0, t1, t2, t3, u4, u5, u6, u7;
    logic signed [fdct_pkg::OPER_W-1:0] operand, q;
    logic mac_load, mac_idle, last_term, finish;
    logic signed [fdct_pkg::ACC_W-1:0] mac_acc;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            xe[i] = fdct_pkg::OPER_W'(x_reg[i]);
        end
    end

    assign e0 = (xe[0] + xe[7] + 20'sd1) >>> 1;
    assign e7 = (xe[0] - xe[7] + 20'sd1) >>> 1;
    assign e1 = (xe[1] + xe[6] + 20'sd1) >>> 1;
    assign e6 = (xe[1] - xe[6] + 20'sd1) >>> 1;
    assign e2 = (xe[2] + xe[5] + 20'sd1) >>> 1;
    assign e5 = (xe[2] - xe[5] + 20'sd1) >>> 1;
    assign e3 = (xe[3] + xe[4] + 20'sd1) >>> 1;
    assign e4 = (xe[3] - xe[4] + 20'sd1) >>> 1;
    assign t0 = e0 + e3;
    assign t3 = e0 - e3;
    assign t1 = e1 + e2;
    assign t2 = e1 - e2;
    assign u4 = e4 + r5_reg;
    assign u5 = e4 - r5_reg;
    assign u7 = e7 + r6_reg;
    assign u6 = e7 - r6_reg;

    always_comb
    begin
        case (step_reg)
            fdct_pkg::STEP_R5: operand = e6 - e5;
            fdct_pkg::STEP_R6: operand = e6 + e5;
            fdct_pkg::STEP_F0: operand = t0 + t1;
            fdct_pkg::STEP_F1: operand = t0 - t1;
            fdct_pkg::STEP_F2: operand = term_reg ? t3 : t2;
            fdct_pkg::STEP_F3: operand = term_reg ? -t2 : t3;
            fdct_pkg::STEP_F4: operand = term_reg ? u7 : u4;
            fdct_pkg::STEP_F7: operand = term_reg ? -u4 : u7;
            fdct_pkg::STEP_F5: operand = term_reg ? u6 : u5;
            fdct_pkg::STEP_F6: operand = term_reg ? -u5 : u6;
            default:           operand = '0;
        endcase
    end

    assign mac_load = (state_reg == ST_ISSUE);

    fdct_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (mac_load),
        .clear    (!term_reg),
        .operand  (operand),
        .constant (fdct_pkg::step_const(step_reg, term_reg)),
        .acc      (mac_acc),
        .idle     (mac_idle)
    );

    assign q         = mac_acc[fdct_pkg::FRAC_W +: fdct_pkg::OPER_W];
    assign y         = q[fdct_pkg::SAMPLE_W-1:0];
    assign last_term = !fdct_pkg::step_two_terms(step_reg) || term_reg;
    assign finish    = (state_reg == ST_WAIT) && mac_idle && last_term;
    assign y_addr    = {fdct_pkg::step_freq(step_reg), row_reg};

    assign s_we    = ((state_reg == ST_COLLECT) && start) ||
                     (finish && pass_reg && (step_reg >= fdct_pkg::STEP_F0));
    assign s_waddr = (state_reg == ST_COLLECT) ? count_reg : y_addr;
    assign s_wdata = (state_reg == ST_COLLECT) ? sample : y;
    assign t_we    = finish && !pass_reg && (step_reg >= fdct_pkg::STEP_F0);
    assign s_raddr = (state_reg == ST_EMIT) ? emit_reg : {row_reg, ld_reg[2:0]};
    assign t_raddr = {row_reg, ld_reg[2:0]};
    assign ld_data = pass_reg ? t_rd_reg : s_rd_reg;

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            s_mem[s_waddr] <= s_wdata;
        end
        s_rd_reg <= s_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            t_mem[y_addr] <= y;
        end
        t_rd_reg <= t_mem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_LOAD) && (ld_reg != 4'd0))
        begin
            x_reg[ld_reg[2:0] - 3'd1] <= ld_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        row_next   = row_reg;
        ld_next    = ld_reg;
        step_next  = step_reg;
        term_next  = term_reg;
        emit_next  = emit_reg;
        r5_next    = r5_reg;
        r6_next    = r6_reg;
        valid_next = (state_reg == ST_EMIT);
        idx_next   = emit_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (start)
                begin
                    count_next = count_reg + 6'd1;
                    if (count_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        pass_next  = 1'b0;
                        row_next   = 3'd0;
                        ld_next    = 4'd0;
                    end
                end
            end
            ST_LOAD:
            begin
                ld_next = ld_reg + 4'd1;
                if (ld_reg == 4'd8)
                begin
                    state_next = ST_ISSUE;
                    step_next  = fdct_pkg::STEP_R5;
                    term_next  = 1'b0;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mac_idle)
                begin
                    if (!last_term)
                    begin
                        term_next  = 1'b1;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        if (step_reg == fdct_pkg::STEP_R5)
                        begin
                            r5_next = q;
                        end
                        if (step_reg == fdct_pkg::STEP_R6)
                        begin
                            r6_next = q;
                        end
                        term_next = 1'b0;
                        step_next = step_reg + 4'd1;
                        state_next = ST_ISSUE;
                        if (step_reg == 4'(fdct_pkg::LAST_STEP))
                        begin
                            ld_next  = 4'd0;
                            row_next = row_reg + 3'd1;
                            state_next = ST_LOAD;
                            if (row_reg == 3'd7)
                            begin
                                pass_next = 1'b1;
                                if (pass_reg)
                                begin
                                    state_next = ST_EMIT;
                                    emit_next  = 6'd0;
                                end
                            end
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                emit_next = emit_reg + 6'd1;
                if (emit_reg == 6'd63)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            count_reg <= 6'd0;
            pass_reg  <= 1'b0;
            row_reg   <= 3'd0;
            ld_reg    <= 4'd0;
            step_reg  <= '0;
            term_reg  <= 1'b0;
            emit_reg  <= 6'd0;
            valid_reg <= 1'b0;
            idx_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pass_reg  <= pass_next;
            row_reg   <= row_next;
            ld_reg    <= ld_next;
            step_reg  <= step_next;
            term_reg  <= term_next;
            emit_reg  <= emit_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r5_reg <= r5_next;
        r6_reg <= r6_next;
    end

    assign busy          = (state_reg != ST_COLLECT);
    assign coef_valid    = valid_reg;
    assign coefficient   = s_rd_reg;
    assign coef_index    = idx_reg;
    assign last_of_block = valid_reg && (idx_reg == 6'd63);

endmodule

// File: design/fdct_checker.sv
// Port-level checker for the 8x8 DCT and its bind to the top level.
module fdct_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  coef_valid,
    input logic        [5:0]                     coef_index,
    input logic                                  last_of_block
);

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_block |-> coef_valid)
        else $error("last_of_block without a result transaction");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (coef_valid && !last_of_block) |=>
            (coef_valid && (coef_index == $past(coef_index) + 6'd1)))
        else $error("result transactions not contiguous in index");

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid |-> (busy || last_of_block))
        else $error("result transaction outside a busy period");

    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !coef_valid)
        else $error("result transaction right after a sample transaction");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_block |=> !busy)
        else $error("block still busy after the last result transaction");

endmodule

bind fixed_point_dct_8x8 fdct_checker u_fdct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .coef_valid    (coef_valid),
    .coef_index    (coef_index),
    .last_of_block (last_of_block)
);

// File: tb/tb.sv
// Self-checking testbench for the fixed-point 8x8 forward DCT with directed and random stimulus.
module tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [15:0] sample = '0;
    logic busy;
    logic coef_valid;
    logic signed [15:0] coefficient;
    logic [5:0] coef_index;
    logic last_of_block;

    localparam logic signed [63:0] K1 = 64'h7D8A;
    localparam logic signed [63:0] K2 = 64'h7641;
    localparam logic signed [63:0] K3 = 64'h6A6D;
    localparam logic signed [63:0] K4 = 64'h5A82;
    localparam logic signed [63:0] K5 = 64'h471C;
    localparam logic signed [63:0] K6 = 64'h30FB;
    localparam logic signed [63:0] K7 = 64'h18F8;

    typedef struct {
        logic signed [15:0] coefficient;
        logic [5:0] coef_index;
        logic last_of_block;
    } coef_t;

    logic signed [15:0] pending_samples[$];
    coef_t expected_coefs[$];
    logic signed [15:0] block_buf[64];
    int block_fill = 0;
    int errors = 0;
    int blocks_done = 0;
    int coefs_seen = 0;
    int idle_left = 0;
    bit quiet_phase = 1'b0;
    bit stim_done = 1'b0;

    fixed_point_dct_8x8 uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .coef_valid(coef_valid), .coefficient(coefficient), .coef_index(coef_index),
        .last_of_block(last_of_block)
    );

    always #4 clk = ~clk;

    function automatic logic signed [63:0] round_q15(input logic signed [63:0] v);
        return (v + 64'sh4000) >>> 15;
    endfunction

    task automatic dct_pass(input logic signed [15:0] x[8], output logic signed [15:0] y[8]);
        logic signed [63:0] e[8];
        logic signed [63:0] t0, t1, t2, t3, r5, r6, u4, u5, u6, u7;
        for (int i = 0; i < 4; i++)
        begin
            e[i] = (64'(x[i]) + 64'(x[7-i]) + 1) >>> 1;
            e[7-i] = (64'(x[i]) - 64'(x[7-i]) + 1) >>> 1;
        end
        t0 = e[0] + e[3];
        t3 = e[0] - e[3];
        t1 = e[1] + e[2];
        t2 = e[1] - e[2];
        r5 = round_q15(e[6] * K4 - e[5] * K4);
        r6 = round_q15(e[6] * K4 + e[5] * K4);
        u4 = e[4] + r5;
        u5 = e[4] - r5;
        u7 = e[7] + r6;
        u6 = e[7] - r6;
        y[0] = 16'(round_q15(t0 * K4 + t1 * K4));
        y[4] = 16'(round_q15(t0 * K4 - t1 * K4));
        y[2] = 16'(round_q15(t2 * K6 + t3 * K2));
        y[6] = 16'(round_q15(t3 * K6 - t2 * K2));
        y[1] = 16'(round_q15(u4 * K7 + u7 * K1));
        y[7] = 16'(round_q15(u7 * K7 - u4 * K1));
        y[5] = 16'(round_q15(u5 * K3 + u6 * K5));
        y[3] = 16'(round_q15(u6 * K3 - u5 * K5));
    endtask

    task automatic predict_coefs();
        logic signed [15:0] trans[64];
        logic signed [15:0] xin[8];
        logic signed [15:0] yout[8];
        coef_t c;
        for (int r = 0; r < 8; r++)
        begin
            for (int k = 0; k < 8; k++)
                xin[k] = block_buf[r*8+k];
            dct_pass(xin, yout);
            for (int k = 0; k < 8; k++)
                trans[k*8+r] = yout[k];
        end
        for (int r = 0; r < 8; r++)
        begin
            for (int k = 0; k < 8; k++)
                xin[k] = trans[r*8+k];
            dct_pass(xin, yout);
            for (int k = 0; k < 8; k++)
                block_buf[k*8+r] = yout[k];
        end
        for (int k = 0; k < 64; k++)
        begin
            c.coefficient = block_buf[k];
            c.coef_index = 6'(k);
            c.last_of_block = (k == 63);
            expected_coefs.push_back(c);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            block_buf[block_fill] = sample;
            if (block_fill == 63)
            begin
                predict_coefs();
                block_fill = 0;
            end
            else
                block_fill++;
        end
        if (!rst_n)
            start <= 1'b0;
        else if (start && !busy)
        begin
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                idle_left = $urandom_range(0, 4);
                start <= 1'b0;
            end
            else if (pending_samples.size() > 0)
                sample <= pending_samples.pop_front();
            else
                start <= 1'b0;
        end
        else if (!start)
        begin
            if (idle_left > 0)
                idle_left--;
            else if (pending_samples.size() > 0)
            begin
                start <= 1'b1;
                sample <= pending_samples.pop_front();
            end
        end
    end

    always @(posedge clk)
    begin
        coef_t e;
        if (rst_n && coef_valid)
        begin
            coefs_seen++;
            if (expected_coefs.size() == 0)
            begin
                $error("unexpected coefficient transaction at index %0d", coef_index);
                errors++;
            end
            else
            begin
                e = expected_coefs.pop_front();
                if (coefficient !== e.coefficient)
                begin
                    $error("coefficient: expected %0d, got %0d", e.coefficient, coefficient);
                    errors++;
                end
                if (coef_index !== e.coef_index)
                begin
                    $error("coef_index: expected %0d, got %0d", e.coef_index, coef_index);
                    errors++;
                end
                if (last_of_block !== e.last_of_block)
                begin
                    $error("last_of_block: expected %0d, got %0d", e.last_of_block,
                           last_of_block);
                    errors++;
                end
                if (e.last_of_block)
                    blocks_done++;
            end
        end
    end

    task automatic queue_block(input int kind);
        logic signed [15:0] v;
        for (int i = 0; i < 64; i++)
        begin
            case (kind)
                0: v = 16'sh7FFF;
                1: v = -16'sh8000;
                2: v = ((i + i / 8) % 2) ? 16'sh7FFF : -16'sh8000;
                3: v = (i % 2) ? -16'sh8000 : 16'sh7FFF;
                4: v = 16'($urandom_range(0, 255)) - 16'sd128;
                default: v = 16'($urandom);
            endcase
            pending_samples.push_back(v);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        queue_block(2);
        queue_block(5);
        wait (pending_samples.size() < 64);
        quiet_phase = 1'b1;
        queue_block(0);
        for (int i = 0; i < 18; i++)
            pending_samples.push_back(16'($urandom));
        wait (pending_samples.size() == 0 && !start);
        wait (expected_coefs.size() == 0);
        repeat (100) @(posedge clk);
        $display("Ran %0d blocks of 64 samples with extreme, checkerboard and random data;",
                 blocks_done);
        $display("checked %0d coefficient transactions.", coefs_seen);
        if (errors == 0 && expected_coefs.size() == 0)
            $display("fixed_point_dct_8x8 regression: pass");
        else
            $display("fixed_point_dct_8x8 regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("fixed_point_dct_8x8 regression: fail");
        $finish;
    end

endmodule
